[design/cgn_pkg.sv]
// package with shared widths, register codes, slot offset table and sequencer types
`default_nettype none

package cgn_pkg;

	localparam int COORD_W    = 6;
	localparam int SLOT_W     = 4;
	localparam int CELL_W     = 18;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THREE_D = 2'd0,
		REG_DIV_X   = 2'd1,
		REG_DIV_Y   = 2'd2,
		REG_DIV_Z   = 2'd3
	} cfg_reg_t;

	// final slot of a base cell in each mode
	localparam logic [SLOT_W-1:0] SLOT_LAST_2D = 4'd3;
	localparam logic [SLOT_W-1:0] SLOT_LAST_3D = 4'd12;

	// per-slot neighbor offset: x and y in {-1, 0, +1}, z in {0, +1}
	typedef struct packed {
		logic neg_x;
		logic pos_x;
		logic neg_y;
		logic pos_y;
		logic pos_z;
	} offset_t;

	// one base cell and slot handed from the sequencer to the pipeline
	typedef struct packed {
		logic               valid;
		logic               last;
		logic [SLOT_W-1:0]  slot;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} issue_t;

	// half-shell offset table in fixed slot order
	function automatic offset_t slot_offset(input logic [SLOT_W-1:0] s);
		offset_t o;
		o = '0;
		unique case (s)
			4'd0:  o = '{neg_x: 1'b0, pos_x: 1'b1, neg_y: 1'b0, pos_y: 1'b0, pos_z: 1'b0};
			4'd1:  o = '{neg_x: 1'b0, pos_x: 1'b1, neg_y: 1'b0, pos_y: 1'b1, pos_z: 1'b0};
			4'd2:  o = '{neg_x: 1'b0, pos_x: 1'b0, neg_y: 1'b0, pos_y: 1'b1, pos_z: 1'b0};
			4'd3:  o = '{neg_x: 1'b1, pos_x: 1'b0, neg_y: 1'b0, pos_y: 1'b1, pos_z: 1'b0};
			4'd4:  o = '{neg_x: 1'b0, pos_x: 1'b1, neg_y: 1'b0, pos_y: 1'b0, pos_z: 1'b1};
			4'd5:  o = '{neg_x: 1'b0, pos_x: 1'b1, neg_y: 1'b0, pos_y: 1'b1, pos_z: 1'b1};
			4'd6:  o = '{neg_x: 1'b0, pos_x: 1'b0, neg_y: 1'b0, pos_y: 1'b1, pos_z: 1'b1};
			4'd7:  o = '{neg_x: 1'b1, pos_x: 1'b0, neg_y: 1'b0, pos_y: 1'b1, pos_z: 1'b1};
			4'd8:  o = '{neg_x: 1'b1, pos_x: 1'b0, neg_y: 1'b0, pos_y: 1'b0, pos_z: 1'b1};
			4'd9:  o = '{neg_x: 1'b1, pos_x: 1'b0, neg_y: 1'b1, pos_y: 1'b0, pos_z: 1'b1};
			4'd10: o = '{neg_x: 1'b0, pos_x: 1'b0, neg_y: 1'b1, pos_y: 1'b0, pos_z: 1'b1};
			4'd11: o = '{neg_x: 1'b0, pos_x: 1'b1, neg_y: 1'b1, pos_y: 1'b0, pos_z: 1'b1};
			4'd12: o = '{neg_x: 1'b0, pos_x: 1'b0, neg_y: 1'b0, pos_y: 1'b0, pos_z: 1'b1};
			default: o = '0;
		endcase
		return o;
	endfunction

endpackage

`default_nettype wire

[design/cgn_in_if.sv]
// base cell channel interface
`default_nettype none

interface cgn_in_if
	import cgn_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] cell_x;
	logic [COORD_W-1:0] cell_y;
	logic [COORD_W-1:0] cell_z;

	modport source (output valid, output cell_x, output cell_y, output cell_z, input ready);
	modport sink   (input valid, input cell_x, input cell_y, input cell_z, output ready);
endinterface

`default_nettype wire

[design/cgn_out_if.sv]
// neighbor result channel interface
`default_nettype none

interface cgn_out_if
	import cgn_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] slot;
	logic              present;
	logic [CELL_W-1:0] neighbor_cell;
	logic              last;

	modport source (
		output valid, output slot, output present, output neighbor_cell, output last,
		input ready
	);
	modport sink (
		input valid, input slot, input present, input neighbor_cell, input last,
		output ready
	);
endinterface

`default_nettype wire

[design/cgn_cfg_if.sv]
// configuration write channel interface
`default_nettype none

interface cgn_cfg_if
	import cgn_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/cgn_cfg.sv]
// configuration registers with saturated grid sizes and the layer size product
`default_nettype none

module cgn_cfg
	import cgn_pkg::*;
#(
	parameter int MAX_DIV = 64
) (
	input  wire                          clk,
	input  wire                          arst_n,
	cgn_cfg_if.sink                      cfg,
	output logic                         three_d,
	output logic [$clog2(MAX_DIV+1)-1:0] dx,
	output logic [$clog2(MAX_DIV+1)-1:0] dy,
	output logic [$clog2(MAX_DIV+1)-1:0] dz,
	output logic [CELL_W-1:0]            plane
);

	localparam int DIV_W  = $clog2(MAX_DIV + 1);
	localparam int CMP_W  = (DIV_W > CFG_DATA_W) ? DIV_W : CFG_DATA_W;
	localparam int PLN_W  = 2 * DIV_W + CELL_W;

	logic                three_d_q;
	logic [DIV_W-1:0]    dx_q;
	logic [DIV_W-1:0]    dy_q;
	logic [DIV_W-1:0]    dz_q;
	logic [CELL_W-1:0]   plane_q;
	logic [DIV_W-1:0]    eff_wr;
	logic [CMP_W-1:0]    data_ext;
	logic [PLN_W-1:0]    plane_x_full;
	logic [PLN_W-1:0]    plane_y_full;
	logic                wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid && cfg.ready;

	// zero reads as one, large values clamp to the grid limit
	always_comb begin
		data_ext = CMP_W'(cfg.data);
		if (cfg.data == '0) begin
			eff_wr = DIV_W'(1);
		end else if (data_ext > CMP_W'(MAX_DIV)) begin
			eff_wr = DIV_W'(MAX_DIV);
		end else begin
			eff_wr = DIV_W'(data_ext);
		end
	end

	// layer size for a write of either planar dimension
	assign plane_x_full = PLN_W'(eff_wr) * PLN_W'(dy_q);
	assign plane_y_full = PLN_W'(dx_q) * PLN_W'(eff_wr);

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			three_d_q <= 1'b0;
			dx_q      <= DIV_W'(1);
			dy_q      <= DIV_W'(1);
			dz_q      <= DIV_W'(1);
			plane_q   <= CELL_W'(1);
		end else if (wr) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_THREE_D: three_d_q <= cfg.data[0];
				REG_DIV_X: begin
					dx_q    <= eff_wr;
					plane_q <= plane_x_full[CELL_W-1:0];
				end
				REG_DIV_Y: begin
					dy_q    <= eff_wr;
					plane_q <= plane_y_full[CELL_W-1:0];
				end
				REG_DIV_Z: dz_q <= eff_wr;
				default: ;
			endcase
		end
	end

	assign three_d = three_d_q;
	assign dx      = dx_q;
	assign dy      = dy_q;
	assign dz      = dz_q;
	assign plane   = plane_q;

endmodule

`default_nettype wire

[design/cgn_seq.sv]
// slot sequencer: holds one base cell and issues its slots one per cycle while issue_ready is high
`default_nettype none

module cgn_seq
	import cgn_pkg::*;
(
	input  wire    clk,
	input  wire    arst_n,
	cgn_in_if.sink base,
	input  wire    three_d,
	input  wire    issue_ready,
	output issue_t issue
);

	logic               busy_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [COORD_W-1:0] base_x_q;
	logic [COORD_W-1:0] base_y_q;
	logic [COORD_W-1:0] base_z_q;
	logic [SLOT_W-1:0]  last_slot;
	logic               is_last;
	logic               fire;
	logic               done;
	logic               take;

	assign last_slot = three_d ? SLOT_LAST_3D : SLOT_LAST_2D;
	assign is_last   = (slot_q == last_slot);
	assign fire      = busy_q && issue_ready;
	assign done      = fire && is_last;

	// next base cell can enter as the last slot of the current one leaves
	assign base.ready = !busy_q || done;
	assign take       = base.valid && base.ready;

	// slot counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			slot_q <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			slot_q <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (fire) begin
			slot_q <= slot_q + SLOT_W'(1);
		end
	end

	// base cell, layer forced to zero in 2D
	always_ff @(posedge clk) begin
		if (take) begin
			base_x_q <= base.cell_x;
			base_y_q <= base.cell_y;
			base_z_q <= three_d ? base.cell_z : '0;
		end
	end

	assign issue = '{valid: busy_q, last: is_last, slot: slot_q,
		x: base_x_q, y: base_y_q, z: base_z_q};

endmodule

`default_nettype wire

[design/cgn_pipe.sv]
// three-stage neighbor pipeline: bounds check, partial products, index sum
`default_nettype none

module cgn_pipe
	import cgn_pkg::*;
#(
	parameter int MAX_DIV = 64
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire issue_t                  issue,
	output logic                         issue_ready,
	input  wire                          three_d,
	input  wire [$clog2(MAX_DIV+1)-1:0]  dx,
	input  wire [$clog2(MAX_DIV+1)-1:0]  dy,
	input  wire [$clog2(MAX_DIV+1)-1:0]  dz,
	input  wire [CELL_W-1:0]             plane,
	cgn_out_if.source                    nbr
);

	localparam int DIV_W  = $clog2(MAX_DIV + 1);
	localparam int NC_W   = COORD_W + 1;
	localparam int CMP_W  = (DIV_W > NC_W) ? DIV_W : NC_W;
	localparam int PROD_W = CELL_W + NC_W + DIV_W;

	// stage 1 registers
	logic              v_s1;
	logic              last_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              ok_s1;
	logic [NC_W-1:0]   nx_s1;
	logic [NC_W-1:0]   ny_s1;
	logic [NC_W-1:0]   nz_s1;

	// stage 2 registers
	logic              v_s2;
	logic              last_s2;
	logic [SLOT_W-1:0] slot_s2;
	logic              ok_s2;
	logic [NC_W-1:0]   nx_s2;
	logic [CELL_W-1:0] pz_s2;
	logic [CELL_W-1:0] py_s2;

	// stage 3 registers, the output register
	logic              v_s3;
	logic              last_s3;
	logic [SLOT_W-1:0] slot_s3;
	logic              ok_s3;
	logic [CELL_W-1:0] cell_s3;

	logic              rdy_s1;
	logic              rdy_s2;
	logic              rdy_s3;

	offset_t           off;
	logic [NC_W-1:0]   nx;
	logic [NC_W-1:0]   ny;
	logic [NC_W-1:0]   nz;
	logic [CMP_W-1:0]  dx_c;
	logic [CMP_W-1:0]  dy_c;
	logic [CMP_W-1:0]  dz_c;
	logic              base_ok;
	logic              ok;
	logic [PROD_W-1:0] pz_full;
	logic [PROD_W-1:0] py_full;
	logic [CELL_W-1:0] sum;

	// each stage moves when it is empty or the next one moves
	assign rdy_s3      = !v_s3 || nbr.ready;
	assign rdy_s2      = !v_s2 || rdy_s3;
	assign rdy_s1      = !v_s1 || rdy_s2;
	assign issue_ready = rdy_s1;

	// stage 1: neighbor coordinates and grid bounds
	always_comb begin
		off  = slot_offset(issue.slot);
		nx   = NC_W'(issue.x) + NC_W'(off.pos_x) - NC_W'(off.neg_x);
		ny   = NC_W'(issue.y) + NC_W'(off.pos_y) - NC_W'(off.neg_y);
		nz   = NC_W'(issue.z) + NC_W'(off.pos_z);
		dx_c = CMP_W'(dx);
		dy_c = CMP_W'(dy);
		dz_c = three_d ? CMP_W'(dz) : CMP_W'(1);
		base_ok = (CMP_W'(issue.x) < dx_c) && (CMP_W'(issue.y) < dy_c)
			&& (CMP_W'(issue.z) < dz_c);
		ok = base_ok
			&& !(off.neg_x && issue.x == '0) && !(off.neg_y && issue.y == '0)
			&& (CMP_W'(nx) < dx_c) && (CMP_W'(ny) < dy_c) && (CMP_W'(nz) < dz_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= issue.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			last_s1 <= issue.last;
			slot_s1 <= issue.slot;
			ok_s1   <= ok;
			nx_s1   <= nx;
			ny_s1   <= ny;
			nz_s1   <= nz;
		end
	end

	// stage 2: layer and row offsets
	assign pz_full = PROD_W'(nz_s1) * PROD_W'(plane);
	assign py_full = PROD_W'(ny_s1) * PROD_W'(dx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			last_s2 <= last_s1;
			slot_s2 <= slot_s1;
			ok_s2   <= ok_s1;
			nx_s2   <= nx_s1;
			pz_s2   <= pz_full[CELL_W-1:0];
			py_s2   <= py_full[CELL_W-1:0];
		end
	end

	// stage 3: linear index, zero for an absent neighbor
	assign sum = pz_s2 + py_s2 + CELL_W'(nx_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			last_s3 <= last_s2;
			slot_s3 <= slot_s2;
			ok_s3   <= ok_s2;
			cell_s3 <= ok_s2 ? sum : '0;
		end
	end

	assign nbr.valid         = v_s3;
	assign nbr.slot          = slot_s3;
	assign nbr.present       = ok_s3;
	assign nbr.neighbor_cell = cell_s3;
	assign nbr.last          = last_s3;

endmodule

`default_nettype wire

[design/cell_grid_neighbor_generator.sv]
// top level of the half-shell neighbor cell generator
//
//   channel  dir  handshake    payload
//   cfg      in   valid/ready  index, data
//   base     in   valid/ready  cell_x, cell_y, cell_z
//   nbr      out  valid/ready  slot, present, neighbor_cell, last
//
// a base cell has 4 slots in 2D and 13 in 3D, issued one per cycle while issue_ready is high
// the next base cell is taken in the cycle its predecessor's last slot is issued
// a result passes the sequencer's base cell register, then the check, products and sum stages
// arst_n clears configuration to 2D with a 1x1x1 grid and empties the pipeline
// a stall on nbr backs up through the stage valid bits; cfg is always ready
`default_nettype none

module cell_grid_neighbor_generator
	import cgn_pkg::*;
#(
	parameter int MAX_DIV = 64
) (
	input  wire       clk,
	input  wire       arst_n,
	cgn_cfg_if.sink   cfg,
	cgn_in_if.sink    base,
	cgn_out_if.source nbr
);

	localparam int DIV_W = $clog2(MAX_DIV + 1);

	logic              three_d;
	logic [DIV_W-1:0]  dx;
	logic [DIV_W-1:0]  dy;
	logic [DIV_W-1:0]  dz;
	logic [CELL_W-1:0] plane;
	logic              issue_ready;
	issue_t            issue;

	// configuration registers
	cgn_cfg #(
		.MAX_DIV (MAX_DIV)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.three_d (three_d),
		.dx      (dx),
		.dy      (dy),
		.dz      (dz),
		.plane   (plane)
	);

	// slot sequencer
	cgn_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.base        (base),
		.three_d     (three_d),
		.issue_ready (issue_ready),
		.issue       (issue)
	);

	// neighbor pipeline
	cgn_pipe #(
		.MAX_DIV (MAX_DIV)
	) u_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.issue       (issue),
		.issue_ready (issue_ready),
		.three_d     (three_d),
		.dx          (dx),
		.dy          (dy),
		.dz          (dz),
		.plane       (plane),
		.nbr         (nbr)
	);

	// the last flag marks only a final slot of either mode
	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		nbr.valid && nbr.last |-> nbr.slot == SLOT_LAST_2D || nbr.slot == SLOT_LAST_3D)
		else $error("last flag on a slot that is not final");

	// absent neighbors carry a zero index
	a_absent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		nbr.valid && !nbr.present |-> nbr.neighbor_cell == '0)
		else $error("absent neighbor with nonzero index");

	// no base cell is taken while a slot other than the last is still pending
	a_take_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		base.valid && base.ready && issue.valid |-> issue.last && issue_ready)
		else $error("base cell taken before its predecessor finished issuing");

	// slots past the planar four appear only in 3D mode
	a_slot_mode: assert property (@(posedge clk) disable iff (!arst_n)
		nbr.valid && nbr.slot > SLOT_LAST_2D |-> three_d)
		else $error("forward layer slot in 2D mode");

endmodule

`default_nettype wire

[tb/sv/cgn_neighbor_checker.sv]
// checker that predicts half-shell neighbor results and compares them with the result channel
`timescale 1ns / 100ps

module cgn_neighbor_checker
	import cgn_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	cgn_cfg_if   cfg,
	cgn_in_if    base,
	cgn_out_if   nbr,
	output int   fails,
	output int   pending
);

	localparam int GRID_LIMIT  = 64;
	localparam int SHELL_SLOTS = 13;
	localparam int PLANE_SLOTS = 4;
	localparam int REPORT_MAX  = 10;

	// per-slot step direction masks, bit n belongs to slot n
	localparam logic [SHELL_SLOTS-1:0] STEP_POS_X = 13'b0100000110011;
	localparam logic [SHELL_SLOTS-1:0] STEP_NEG_X = 13'b0001110001000;
	localparam logic [SHELL_SLOTS-1:0] STEP_POS_Y = 13'b0000011101110;
	localparam logic [SHELL_SLOTS-1:0] STEP_NEG_Y = 13'b0111000000000;
	localparam logic [SHELL_SLOTS-1:0] STEP_POS_Z = 13'b1111111110000;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              present;
		logic [CELL_W-1:0] nbr_index;
		logic              last;
	} nbr_result_t;

	logic                  grid_3d;
	logic [CFG_DATA_W-1:0] grid_div_x;
	logic [CFG_DATA_W-1:0] grid_div_y;
	logic [CFG_DATA_W-1:0] grid_div_z;
	nbr_result_t           neighbor_q[$];

	// zero counts as one cell, large counts saturate at the grid limit
	function automatic int clamp_div(input logic [CFG_DATA_W-1:0] d);
		if (d == '0)
			return 1;
		if (int'(d) > GRID_LIMIT)
			return GRID_LIMIT;
		return int'(d);
	endfunction

	// queue every neighbor slot of one base cell under the current grid setup
	function automatic void queue_half_shell(input logic [COORD_W-1:0] cx,
		input logic [COORD_W-1:0] cy, input logic [COORD_W-1:0] cz);
		int gx;
		int gy;
		int gz;
		int bz;
		int count;
		int nx;
		int ny;
		int nz;
		logic base_in_grid;
		nbr_result_t r;
		gx = clamp_div(grid_div_x);
		gy = clamp_div(grid_div_y);
		gz = grid_3d ? clamp_div(grid_div_z) : 1;
		bz = grid_3d ? int'(cz) : 0;
		count = grid_3d ? SHELL_SLOTS : PLANE_SLOTS;
		base_in_grid = (int'(cx) < gx) && (int'(cy) < gy) && (bz < gz);
		for (int s = 0; s < count; s++) begin
			nx = int'(cx) + int'(STEP_POS_X[s]) - int'(STEP_NEG_X[s]);
			ny = int'(cy) + int'(STEP_POS_Y[s]) - int'(STEP_NEG_Y[s]);
			nz = bz + int'(STEP_POS_Z[s]);
			r.slot      = SLOT_W'(s);
			r.present   = base_in_grid && nx >= 0 && nx < gx && ny >= 0 && ny < gy
				&& nz < gz;
			r.nbr_index = r.present ? CELL_W'(nz * gx * gy + ny * gx + nx) : '0;
			r.last      = (s == count - 1);
			neighbor_q.push_back(r);
		end
	endfunction

	// track configuration, check results, predict on each base cell transaction
	always @(posedge clk or negedge arst_n) begin
		nbr_result_t want;
		if (!arst_n) begin
			grid_3d    <= 1'b0;
			grid_div_x <= CFG_DATA_W'(1);
			grid_div_y <= CFG_DATA_W'(1);
			grid_div_z <= CFG_DATA_W'(1);
			neighbor_q.delete();
			fails   = 0;
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg_reg_t'(cfg.index))
					REG_THREE_D: grid_3d    <= cfg.data[0];
					REG_DIV_X:   grid_div_x <= cfg.data;
					REG_DIV_Y:   grid_div_y <= cfg.data;
					REG_DIV_Z:   grid_div_z <= cfg.data;
					default: ;
				endcase
			end
			if (nbr.valid && nbr.ready) begin
				if (neighbor_q.size() == 0) begin
					if (fails < REPORT_MAX)
						$display("unexpected result: slot %0d present %0d cell %0d last %0d",
							nbr.slot, nbr.present, nbr.neighbor_cell, nbr.last);
					fails++;
				end else begin
					want = neighbor_q.pop_front();
					if (nbr.slot !== want.slot || nbr.present !== want.present
						|| nbr.neighbor_cell !== want.nbr_index
						|| nbr.last !== want.last) begin
						if (fails < REPORT_MAX) begin
							$write("neighbor mismatch: expected slot %0d present %0d",
								want.slot, want.present);
							$write(" cell %0d last %0d,", want.nbr_index, want.last);
							$write(" got slot %0d present %0d", nbr.slot, nbr.present);
							$display(" cell %0d last %0d", nbr.neighbor_cell, nbr.last);
						end
						fails++;
					end
				end
			end
			if (base.valid && base.ready)
				queue_half_shell(base.cell_x, base.cell_y, base.cell_z);
			pending <= neighbor_q.size();
		end
	end

endmodule

[tb/sv/tb_cell_grid_neighbor_generator.sv]
// top of the neighbor generator testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_cell_grid_neighbor_generator;
	import cgn_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 6;
	localparam int RESET_CYCLES = 12;
	localparam int RAND_PHASES  = 6;
	localparam int PHASE_CELLS  = 18;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	int   cycle_count = 0;
	int   send_idle_pct;
	int   recv_idle_pct;
	logic [CFG_DATA_W-1:0] rnd_div_x;
	logic [CFG_DATA_W-1:0] rnd_div_y;
	logic [CFG_DATA_W-1:0] rnd_div_z;

	cgn_cfg_if cfg_ch ();
	cgn_in_if  base_ch ();
	cgn_out_if nbr_ch ();

	cell_grid_neighbor_generator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.base   (base_ch),
		.nbr    (nbr_ch)
	);

	cgn_neighbor_checker shell_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.base    (base_ch),
		.nbr     (nbr_ch),
		.fails   (fails),
		.pending (pending)
	);

	// 20 ns clock
	always #10 clk = ~clk;

	// result receiver with random stalls
	always @(posedge clk) begin
		nbr_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_cell_grid_neighbor_generator NOT OK");
			$finish;
		end
	end

	// one register write transaction, valid stays high for a following write
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		logic taken;
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do begin
			@(negedge clk);
			taken = cfg_ch.ready;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic set_grid(input logic three_d, input logic [CFG_DATA_W-1:0] dx,
		input logic [CFG_DATA_W-1:0] dy, input logic [CFG_DATA_W-1:0] dz);
		write_reg(REG_THREE_D, CFG_DATA_W'(three_d));
		write_reg(REG_DIV_X, dx);
		write_reg(REG_DIV_Y, dy);
		write_reg(REG_DIV_Z, dz);
		cfg_ch.valid <= 1'b0;
	endtask

	// one base cell transaction with random leading gaps
	task automatic send_cell(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
		input logic [COORD_W-1:0] z);
		logic taken;
		while ($urandom_range(99) < send_idle_pct) begin
			base_ch.valid <= 1'b0;
			@(posedge clk);
		end
		base_ch.valid  <= 1'b1;
		base_ch.cell_x <= x;
		base_ch.cell_y <= y;
		base_ch.cell_z <= z;
		do begin
			@(negedge clk);
			taken = base_ch.ready;
			@(posedge clk);
		end while (!taken);
	endtask

	// let every expected result come out, then give the pipeline time to empty
	task automatic settle();
		base_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// grid size: mostly small, sometimes zero or at or beyond the saturation point
	function automatic logic [CFG_DATA_W-1:0] rand_div();
		int pick;
		pick = $urandom_range(99);
		if (pick < 6)
			return '0;
		if (pick < 12)
			return CFG_DATA_W'($urandom_range(127, 64));
		if (pick < 20)
			return CFG_DATA_W'($urandom_range(63, 9));
		return CFG_DATA_W'($urandom_range(8, 1));
	endfunction

	// coordinate mostly inside the grid, sometimes anywhere in the field
	function automatic logic [COORD_W-1:0] rand_coord(input logic [CFG_DATA_W-1:0] d);
		int span;
		span = (d == '0) ? 1 : ((int'(d) > 64) ? 64 : int'(d));
		if ($urandom_range(99) < 15)
			return COORD_W'($urandom_range(63));
		return COORD_W'($urandom_range(span - 1));
	endfunction

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		send_idle_pct  = 8;
		recv_idle_pct  = 57;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = REG_THREE_D;
		cfg_ch.data    = '0;
		base_ch.valid  = 1'b0;
		base_ch.cell_x = '0;
		base_ch.cell_y = '0;
		base_ch.cell_z = '0;
		nbr_ch.ready   = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 2D, 5x4: corners, edges, ignored z and cells outside the grid
		set_grid(1'b0, 7'd5, 7'd4, 7'd9);
		send_cell(6'd0, 6'd0, 6'd37);
		send_cell(6'd4, 6'd0, 6'd0);
		send_cell(6'd0, 6'd3, 6'd0);
		send_cell(6'd4, 6'd3, 6'd63);
		send_cell(6'd2, 6'd1, 6'd0);
		send_cell(6'd5, 6'd0, 6'd0);
		send_cell(6'd0, 6'd4, 6'd0);
		send_cell(6'd63, 6'd63, 6'd63);
		settle();

		// 3D, 4x3x3: right edge for forward lower right, top layer, outside cells
		set_grid(1'b1, 7'd4, 7'd3, 7'd3);
		send_cell(6'd0, 6'd0, 6'd0);
		send_cell(6'd3, 6'd1, 6'd0);
		send_cell(6'd1, 6'd1, 6'd2);
		send_cell(6'd3, 6'd2, 6'd1);
		send_cell(6'd1, 6'd0, 6'd1);
		send_cell(6'd0, 6'd0, 6'd3);
		send_cell(6'd4, 6'd0, 6'd0);
		send_cell(6'd63, 6'd63, 6'd63);
		settle();

		// zero sizes act as a single cell
		set_grid(1'b1, 7'd0, 7'd0, 7'd0);
		send_cell(6'd0, 6'd0, 6'd0);
		send_cell(6'd1, 6'd0, 6'd0);
		settle();

		// oversized counts saturate, largest cell indexes
		set_grid(1'b1, 7'd127, 7'd64, 7'd100);
		send_cell(6'd63, 6'd63, 6'd62);
		send_cell(6'd0, 6'd0, 6'd0);
		send_cell(6'd63, 6'd0, 6'd0);
		send_cell(6'd62, 6'd63, 6'd0);
		settle();

		// random grids and cells under three idling regimes
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			if (phase == 2) begin
				send_idle_pct = 57;
				recv_idle_pct = 8;
			end else if (phase == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			rnd_div_x = rand_div();
			rnd_div_y = rand_div();
			rnd_div_z = rand_div();
			set_grid(phase % 2 == 1, rnd_div_x, rnd_div_y, rnd_div_z);
			repeat (PHASE_CELLS)
				send_cell(rand_coord(rnd_div_x), rand_coord(rnd_div_y), rand_coord(rnd_div_z));
			settle();
		end

		if (fails == 0 && pending == 0) begin
			$display("tb_cell_grid_neighbor_generator OK");
		end else begin
			$display("tb_cell_grid_neighbor_generator NOT OK");
		end
		$finish;
	end

endmodule
